@@ sv/frlc_pkg.sv @@
// ----------------------------------------------------------------------------
// frlc_pkg
// Shared types and constants for the FIFO-replacement lookup cache.
// ----------------------------------------------------------------------------
package frlc_pkg;

  // Cache geometry
  localparam int DEPTH     = 32;
  localparam int KEY_WIDTH = 64;
  localparam int AW        = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W     = $clog2(DEPTH + 1);

  // Command codes
  typedef enum logic [1:0] {
    CMD_LOOKUP = 2'd0,
    CMD_FILL   = 2'd1,
    CMD_INVAL  = 2'd2,
    CMD_CLEAR  = 2'd3
  } cmd_t;

  // Sequencer states
  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_ACT,
    S_SHIFT
  } state_t;

endpackage

@@ sv/fifo_replacement_lookup_cache_top.sv @@
// ----------------------------------------------------------------------------
// fifo_replacement_lookup_cache_top
// Fully associative key to one-bit cache, age-ordered, FIFO replacement.
// ----------------------------------------------------------------------------
// One command is handled at a time. The entry memory has a single registered
// read port and a single write port, and every pass over the entries runs
// one entry per cycle through it. An accepted command scans the entries in
// order, stopping at the first match (no scan when the cache is empty), then
// goes through a decision state, and, for an invalidate that hits or a
// fill that misses in a full cache, a compaction pass that moves each entry
// above the removed slot down by one; an evicting fill then writes the new
// entry into the top slot. The result is held in an output register; the
// next command is taken once that result has been transferred (or in the
// same cycle as its transfer). Clear empties the cache by resetting the
// entry count in the decision state.
// ----------------------------------------------------------------------------
module fifo_replacement_lookup_cache_top
  import frlc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // command channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  cmd,
  input  logic [63:0] key,
  input  logic        new_value,
  // result channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic        hit,
  output logic        cached_value
);

  // Sequencer and command registers
  state_t                 state, state_next;
  cmd_t                   cmd_r;
  logic [KEY_WIDTH-1:0]   key_r;
  logic                   val_r;
  logic [CNT_W-1:0]       count;

  // Scan / shift pointers
  logic [CNT_W-1:0]       ptr;
  logic                   lag_vld;
  logic [AW-1:0]          lag_idx;

  // Scan outcome
  logic                   found;
  logic [AW-1:0]          slot;
  logic                   hit_val;
  logic                   append;

  // Entry memory: {value, key}
  logic [KEY_WIDTH:0]     mem [DEPTH];
  logic [KEY_WIDTH:0]     rd_data;
  logic                   rd_en;
  logic [AW-1:0]          rd_addr;
  logic                   we;
  logic [AW-1:0]          wr_addr;
  logic [KEY_WIDTH:0]     wr_data;

  // Control decodes
  logic                   accept;
  logic                   match;
  logic                   scan_last;
  logic                   issue;
  logic                   shift_done;
  logic                   finish;
  logic [CNT_W-1:0]       pos_next;
  logic                   start_shift;

  assign accept    = in_valid && in_ready;
  assign match     = lag_vld && (rd_data[KEY_WIDTH-1:0] == key_r);
  assign scan_last = lag_vld && ((CNT_W'(lag_idx) + CNT_W'(1)) == count);
  assign issue     = (ptr < count);
  assign shift_done = !lag_vld && !issue;

  // Start of a compaction pass decided in the action cycle
  always_comb begin
    start_shift = 1'b0;
    pos_next    = '0;
    case (cmd_r)
      CMD_FILL: begin
        if (!found && (count == CNT_W'(DEPTH))) begin
          start_shift = 1'b1;
          pos_next    = CNT_W'(1);
        end
      end
      CMD_INVAL: begin
        if (found) begin
          start_shift = 1'b1;
          pos_next    = CNT_W'(slot) + CNT_W'(1);
        end
      end
      default: begin
        start_shift = 1'b0;
      end
    endcase
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = (count == '0) ? S_ACT : S_SCAN;
        end
      end
      S_SCAN: begin
        if (match || scan_last) begin
          state_next = S_ACT;
        end
      end
      S_ACT: begin
        state_next = start_shift ? S_SHIFT : S_IDLE;
      end
      S_SHIFT: begin
        if (shift_done) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Memory port control and handshake outputs
  always_comb begin
    in_ready = (state == S_IDLE) && (!out_valid || out_ready);
    rd_en    = 1'b0;
    rd_addr  = ptr[AW-1:0];
    we       = 1'b0;
    wr_addr  = lag_idx - AW'(1);
    wr_data  = rd_data;
    finish   = 1'b0;
    case (state)
      S_SCAN: begin
        rd_en = issue;
      end
      S_ACT: begin
        finish = !start_shift;
        if (cmd_r == CMD_FILL) begin
          if (found) begin
            we      = 1'b1;
            wr_addr = slot;
            wr_data = {val_r, key_r};
          end else if (count != CNT_W'(DEPTH)) begin
            we      = 1'b1;
            wr_addr = count[AW-1:0];
            wr_data = {val_r, key_r};
          end
        end
      end
      S_SHIFT: begin
        rd_en  = issue;
        finish = shift_done;
        if (lag_vld) begin
          we = 1'b1;
        end else if (shift_done && append) begin
          // evicting fill: new entry goes into the top slot
          we      = 1'b1;
          wr_addr = AW'(DEPTH - 1);
          wr_data = {val_r, key_r};
        end
      end
      default: begin
        rd_en = 1'b0;
      end
    endcase
  end

  // Entry memory
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  // Sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Command capture
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r <= cmd_t'(cmd);
      key_r <= key[KEY_WIDTH-1:0];
      val_r <= new_value;
    end
  end

  // Pointers, scan outcome and entry count
  always_ff @(posedge clk) begin
    if (rst) begin
      count   <= '0;
      lag_vld <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          lag_vld <= 1'b0;
          if (accept) begin
            ptr   <= '0;
            found <= 1'b0;
          end
        end
        S_SCAN: begin
          if (match) begin
            found   <= 1'b1;
            slot    <= lag_idx;
            hit_val <= rd_data[KEY_WIDTH];
          end
          lag_vld <= issue;
          if (issue) begin
            ptr     <= ptr + CNT_W'(1);
            lag_idx <= ptr[AW-1:0];
          end
        end
        S_ACT: begin
          lag_vld <= 1'b0;
          ptr     <= pos_next;
          append  <= (cmd_r == CMD_FILL);
          if (cmd_r == CMD_CLEAR) begin
            count <= '0;
          end else if (cmd_r == CMD_FILL && !found && count != CNT_W'(DEPTH)) begin
            count <= count + CNT_W'(1);
          end
        end
        S_SHIFT: begin
          lag_vld <= issue;
          if (issue) begin
            ptr     <= ptr + CNT_W'(1);
            lag_idx <= ptr[AW-1:0];
          end
          if (shift_done && !append) begin
            count <= count - CNT_W'(1);
          end
        end
        default: begin
          lag_vld <= 1'b0;
        end
      endcase
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (finish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      hit          <= found;
      cached_value <= found && hit_val && (cmd_r == CMD_LOOKUP);
    end
  end

endmodule
